// File: rtl/ep0dr_pkg.sv
// ----------------------------------------------------------------------------
// ep0dr_pkg
// Types, descriptor ROM contents and command words shared by the EP0
// descriptor responder.
// ----------------------------------------------------------------------------
package ep0dr_pkg;

	localparam logic [15:0] BCD_RESET = 16'h0110;

	// descriptor selector codes
	localparam logic [2:0] DESC_DEVICE = 3'd0;
	localparam logic [2:0] DESC_CONFIG = 3'd1;
	localparam logic [2:0] DESC_LANGID = 3'd2;
	localparam logic [2:0] DESC_PRODUCT = 3'd3;
	localparam logic [2:0] DESC_MANUF = 3'd4;
	localparam logic [2:0] DESC_REPORT = 3'd5;
	localparam logic [2:0] DESC_NUM = 3'd6;
	localparam logic [2:0] SEL_NONE = 3'd7;

	localparam int DESC_COUNT = 6;

	// packet id codes
	localparam logic [1:0] PID_SETUP = 2'd0;
	localparam logic [1:0] PID_IN = 2'd2;

	// {wValue, bRequest, bmRequestType} of each GetDescriptor request
	localparam logic [31:0] DESC_CMD [DESC_COUNT] = '{
		32'h01000680, 32'h02000680, 32'h03000680,
		32'h03020680, 32'h03010680, 32'h22000681
	};

	localparam logic [6:0] DESC_LEN [DESC_COUNT] = '{
		7'd18, 7'd34, 7'd4, 7'd40, 7'd10, 7'd65
	};

	localparam logic [7:0] ROM_DEV [18] = '{
		8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08,
		8'h00, 8'h00, 8'h01, 8'h00, 8'h06, 8'h03, 8'h01, 8'h02,
		8'h00, 8'h01
	};

	localparam logic [7:0] ROM_CFG [34] = '{
		8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'ha0,
		8'h23, 8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01,
		8'h01, 8'h00, 8'h09, 8'h21, 8'h10, 8'h01, 8'h00, 8'h01,
		8'h22, 8'h41, 8'h00, 8'h07, 8'h05, 8'h81, 8'h03, 8'h08,
		8'h00, 8'h0a
	};

	localparam logic [7:0] ROM_LANG [4] = '{
		8'h04, 8'h03, 8'h09, 8'h04
	};

	localparam logic [7:0] ROM_PROD [40] = '{
		8'h28, 8'h03, 8'h42, 8'h00, 8'h69, 8'h00, 8'h74, 8'h00,
		8'h56, 8'h00, 8'h69, 8'h00, 8'h73, 8'h00, 8'h6f, 8'h00,
		8'h72, 8'h00, 8'h20, 8'h00, 8'h55, 8'h00, 8'h53, 8'h00,
		8'h42, 8'h00, 8'h20, 8'h00, 8'h44, 8'h00, 8'h65, 8'h00,
		8'h76, 8'h00, 8'h69, 8'h00, 8'h63, 8'h00, 8'h65, 8'h00
	};

	localparam logic [7:0] ROM_MANUF [10] = '{
		8'h0a, 8'h03, 8'h49, 8'h00, 8'h47, 8'h00, 8'h45, 8'h00,
		8'h4c, 8'h00
	};

	localparam logic [7:0] ROM_REPORT [65] = '{
		8'h05, 8'h01, 8'h09, 8'h06, 8'ha1, 8'h01, 8'h05, 8'h07,
		8'h19, 8'he0, 8'h29, 8'he7, 8'h15, 8'h00, 8'h25, 8'h01,
		8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h95, 8'h01,
		8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h03, 8'h75, 8'h01,
		8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h03, 8'h91, 8'h02,
		8'h95, 8'h01, 8'h75, 8'h05, 8'h91, 8'h01, 8'h95, 8'h06,
		8'h75, 8'h08, 8'h15, 8'h00, 8'h26, 8'hff, 8'h00, 8'h05,
		8'h07, 8'h19, 8'h00, 8'h2a, 8'hff, 8'h00, 8'h81, 8'h00,
		8'hc0
	};

	typedef enum logic [1:0] {
		JOB_SETUP,
		JOB_ACK,
		JOB_IN
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [6:0] buflen;    // td_length saturated to the buffer limit
		logic [2:0] sel;       // matched descriptor, SEL_NONE if no match
		logic [6:0] setup_len; // min(wLength, descriptor length)
	} job_t;

	function automatic logic [7:0] rom_byte(input logic [2:0] sel,
			input logic [6:0] pos, input logic [15:0] bcd);
		logic [7:0] b;
		b = 8'h00;
		case (sel)
			DESC_DEVICE: begin
				if (pos == 7'd2)
					b = bcd[7:0];
				else if (pos == 7'd3)
					b = bcd[15:8];
				else if (pos < 7'd18)
					b = ROM_DEV[pos[4:0]];
			end
			DESC_CONFIG: begin
				if (pos < 7'd34)
					b = ROM_CFG[pos[5:0]];
			end
			DESC_LANGID: begin
				if (pos < 7'd4)
					b = ROM_LANG[pos[1:0]];
			end
			DESC_PRODUCT: begin
				if (pos < 7'd40)
					b = ROM_PROD[pos[5:0]];
			end
			DESC_MANUF: begin
				if (pos < 7'd10)
					b = ROM_MANUF[pos[3:0]];
			end
			DESC_REPORT: begin
				if (pos < 7'd65)
					b = ROM_REPORT[pos];
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/ep0dr_if.sv
// ----------------------------------------------------------------------------
// ep0dr_req_if / ep0dr_rsp_if
// Valid/ready channels for transfer requests and per-byte results.
// ----------------------------------------------------------------------------
interface ep0dr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  packet_id;
	logic [6:0]  td_length;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] requested_length;

	modport source(output valid, packet_id, td_length, request_type, request_code,
		request_value, requested_length, input ready);
	modport sink(input valid, packet_id, td_length, request_type, request_code,
		request_value, requested_length, output ready);
endinterface

interface ep0dr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic [6:0] reply_length;
	logic       reply_status;
	logic       last;

	modport source(output valid, data_byte, byte_valid, reply_length, reply_status,
		last, input ready);
	modport sink(input valid, data_byte, byte_valid, reply_length, reply_status,
		last, output ready);
endinterface

// File: rtl/usb_ep0_descriptor_responder_core.sv
// A request reaches the job queue on acceptance; its first result is
// registered in the cycle after the engine pops it, except an IN with data,
// which enters the stream state and streams one byte per cycle from the
// descriptor ROM while rsp.ready allows; no new job is popped until it ends.
// Reset (arst_n low): no descriptor selected, offset and bytes left zero,
// job queue empty, bcdUSB register back to 0x0110. No clearing pass.
// ----------------------------------------------------------------------------
// usb_ep0_descriptor_responder_core
// Control endpoint 0 that answers GetDescriptor with fixed ROM descriptors.
// ----------------------------------------------------------------------------
module usb_ep0_descriptor_responder_core import ep0dr_pkg::*; #(
	parameter int MAX_TD_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ep0dr_req_if.sink   req,
	ep0dr_rsp_if.source rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] bcd_q;
	logic        q_full;
	logic        push;
	job_t        push_job;
	logic        job_valid;
	logic        job_pop;
	job_t        job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bcd_q <= BCD_RESET;
		else if (cfg_we)
			bcd_q <= cfg_wdata;
	end

	ep0dr_front #(
		.MAX_TD_BYTES(MAX_TD_BYTES)
	) u_front (
		.req     (req),
		.q_full  (q_full),
		.push    (push),
		.push_job(push_job)
	);

	ep0dr_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (job_pop),
		.pop_valid(job_valid),
		.pop_job  (job)
	);

	ep0dr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bcd      (bcd_q),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop),
		.rsp      (rsp)
	);

endmodule

// File: rtl/ep0dr_front.sv
// ----------------------------------------------------------------------------
// ep0dr_front
// Accepts requests, saturates the buffer length and matches setup commands
// against the descriptor table; pushes one job per request.
// ----------------------------------------------------------------------------
module ep0dr_front import ep0dr_pkg::*; #(
	parameter int MAX_TD_BYTES = 64
) (
	ep0dr_req_if.sink req,
	input  logic      q_full,
	output logic      push,
	output job_t      push_job
);

	localparam logic [6:0] MAX_TD = 7'(MAX_TD_BYTES);

	logic [31:0] cmd;
	logic [6:0]  buflen;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	assign cmd    = {req.request_value, req.request_code, req.request_type};
	assign buflen = (req.td_length > MAX_TD) ? MAX_TD : req.td_length;

	always_comb begin
		push_job.buflen    = buflen;
		push_job.sel       = SEL_NONE;
		push_job.setup_len = 7'd0;
		case (req.packet_id)
			PID_SETUP: push_job.kind = JOB_SETUP;
			PID_IN:    push_job.kind = JOB_IN;
			default:   push_job.kind = JOB_ACK;
		endcase
		for (int i = 0; i < DESC_COUNT; i++) begin
			if (cmd == DESC_CMD[i]) begin
				push_job.sel = 3'(i);
				push_job.setup_len = (req.requested_length < {9'd0, DESC_LEN[i]}) ?
					req.requested_length[6:0] : DESC_LEN[i];
			end
		end
	end

endmodule

// File: rtl/ep0dr_job_fifo.sv
// ----------------------------------------------------------------------------
// ep0dr_job_fifo
// Two-entry job queue between the classifier and the reply engine.
// ----------------------------------------------------------------------------
module ep0dr_job_fifo import ep0dr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/ep0dr_back.sv
// ----------------------------------------------------------------------------
// ep0dr_back
// Reply engine: owns the selected descriptor, offset and bytes left, and
// streams descriptor bytes into the result register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module ep0dr_back import ep0dr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] bcd,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	ep0dr_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} state_t;

	state_t     st_q;
	logic [2:0] sel_q;
	logic [6:0] offset_q;
	logic [6:0] left_q;
	logic [6:0] cnt_q;
	logic [6:0] nlen_q;
	logic       short_q;
	logic       rsp_valid_q;
	logic [7:0] data_q;
	logic       bvalid_q;
	logic [6:0] len_q;
	logic       status_q;
	logic       last_q;

	logic       out_load;
	logic       in_nodata;
	logic       in_start;
	logic       stream_emit;
	logic       emit;
	logic [6:0] n_in;

	assign out_load = !rsp_valid_q || rsp.ready;
	assign job_pop  = (st_q == ST_IDLE) && job_valid && out_load;

	// an IN with nothing to send still gets a zero-length result
	assign in_nodata = (sel_q >= DESC_NUM) || (left_q == 7'd0) || (job.buflen == 7'd0);
	assign in_start  = job_pop && (job.kind == JOB_IN) && !in_nodata;
	assign n_in      = (job.buflen < left_q) ? job.buflen : left_q;

	assign stream_emit = (st_q == ST_STREAM) && out_load;
	assign emit        = (job_pop && !in_start) || stream_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			sel_q       <= SEL_NONE;
			offset_q    <= 7'd0;
			left_q      <= 7'd0;
			cnt_q       <= 7'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (job_pop && job.kind == JOB_SETUP) begin
						sel_q    <= job.sel;
						offset_q <= 7'd0;
						left_q   <= job.setup_len;
					end
					if (in_start) begin
						cnt_q <= n_in;
						st_q  <= ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (out_load) begin
						offset_q <= offset_q + 7'd1;
						left_q   <= left_q - 7'd1;
						cnt_q    <= cnt_q - 7'd1;
						if (cnt_q == 7'd1)
							st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_start) begin
			nlen_q  <= n_in;
			short_q <= (n_in < job.buflen);
		end
		if (stream_emit) begin
			data_q   <= rom_byte(sel_q, offset_q, bcd);
			bvalid_q <= 1'b1;
			len_q    <= nlen_q;
			status_q <= short_q;
			last_q   <= (cnt_q == 7'd1);
		end else if (emit) begin
			data_q   <= 8'h00;
			bvalid_q <= 1'b0;
			last_q   <= 1'b1;
			if (job.kind == JOB_IN) begin
				len_q    <= 7'd0;
				status_q <= (job.buflen != 7'd0);
			end else begin
				len_q    <= job.buflen;
				status_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.data_byte    = data_q;
	assign rsp.byte_valid   = bvalid_q;
	assign rsp.reply_length = len_q;
	assign rsp.reply_status = status_q;
	assign rsp.last         = last_q;

endmodule

// File: rtl/ep0dr_checker.sv
// ----------------------------------------------------------------------------
// ep0dr_checker
// Port-level checks on the result channel of the descriptor responder.
// ----------------------------------------------------------------------------
module ep0dr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] data_byte,
	input logic       byte_valid,
	input logic [6:0] reply_length,
	input logic       reply_status,
	input logic       last
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_byte) &&
		$stable(byte_valid) && $stable(reply_length) &&
		$stable(reply_status) && $stable(last))
		else $error("result changed while stalled");

	// non-data results are single, zero-filled and end the transfer
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_valid |-> last && data_byte == 8'h00)
		else $error("non-data result not last or not zero");

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && byte_valid |-> reply_length != 7'd0)
		else $error("data byte with zero reply length");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> reply_length <= 7'd64)
		else $error("reply length beyond buffer size");

endmodule

bind usb_ep0_descriptor_responder_core ep0dr_checker u_ep0dr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.data_byte   (rsp.data_byte),
	.byte_valid  (rsp.byte_valid),
	.reply_length(rsp.reply_length),
	.reply_status(rsp.reply_status),
	.last        (rsp.last)
);
